// ===== hdl/assert_macros.svh =====
// Assertion helper macros included by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define CHK_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included
`define CHK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/dta_pkg.sv =====
`default_nettype none
package dta_pkg;
    localparam logic [2:0] OP_ALLOC    = 3'd0;
    localparam logic [2:0] OP_REQUEST  = 3'd1;
    localparam logic [2:0] OP_ACQUIRED = 3'd2;
    localparam logic [2:0] OP_RELEASED = 3'd3;
    localparam logic [2:0] OP_PARK     = 3'd4;
    localparam logic [2:0] OP_RESUME   = 3'd5;

    localparam logic [0:0] CFG_ENABLE    = 1'd0;
    localparam logic [0:0] CFG_RETRY_CAP = 1'd1;

    localparam logic [31:0] RETRY_RESET = 32'd50000;
    localparam logic [7:0]  DEPTH_MAX   = 8'hFF;
    localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [2:0] op;
        logic [5:0] slot;
        logic       with_advance;
    } t_in_item;

    typedef struct packed {
        logic        grant;
        logic        relaxed;
        logic [5:0]  new_slot;
        logic        table_full;
        logic        was_active;
        logic [31:0] relax_total;
    } t_out_item;
endpackage
`default_nettype wire

// ===== hdl/dta_in_if.sv =====
`default_nettype none
interface dta_in_if;
    logic              valid;
    logic              ready;
    dta_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/dta_out_if.sv =====
`default_nettype none
interface dta_out_if;
    logic               valid;
    logic               ready;
    dta_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/dta_slot_ram.sv =====
`default_nettype none
// Slot table: one word per slot {active, depth, retry, clock}, one read and one write port
module dta_slot_ram #(
    parameter int AW = 6,
    parameter int DW = 73
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output      logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [2**AW];

    // write then registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/deterministic_turn_arbiter_top.sv =====
`default_nettype none
// Deterministic turn arbiter. All slot state sits in one single-port-read
// memory word per slot; allocate writes a fresh word, other events read the
// item's word and write back any change. Allocate, acquired, released, park,
// resume, undefined codes and a turn request granted outright (disabled or
// unregistered slot) pass through the read, modify and output states. A
// turn request on a registered slot while enabled that already holds a lock
// goes from modify through the done state to output. Any other turn request
// reads the requesting slot, then scans slots 0..slots_used-1 through the
// same read port, one per cycle, before the done and output states. One
// item is in flight at a time; the result sits in an output register, and
// the next item is taken once that register has been emptied. Data read
// from entries past slots_used is never used, so no clearing pass is needed.
module deterministic_turn_arbiter_top #(
    parameter int SLOTS      = 64,
    parameter int CLOCK_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    dta_in_if.sink           in_ch,
    dta_out_if.source        out_ch,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int DW = 1 + 8 + 32 + CLOCK_BITS;
    localparam logic [CLOCK_BITS-1:0] CLOCK_MAX = {CLOCK_BITS{1'b1}};

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_MOD  = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]            r_state;
    logic                  r_enable;
    logic [31:0]           r_cap;
    logic [CW-1:0]         r_used;
    logic [31:0]           r_relax;
    dta_pkg::t_in_item     r_item;
    logic                  r_reg;
    logic [DW-1:0]         r_self;
    logic [CW-1:0]         r_idx;
    logic                  r_scan_v;
    logic [AW-1:0]         r_scan_a;
    logic                  r_lose;
    logic                  r_ovalid;
    dta_pkg::t_out_item    r_out;

    logic                  we;
    logic [AW-1:0]         waddr;
    logic [DW-1:0]         wdata;
    logic [AW-1:0]         raddr;
    logic [DW-1:0]         rdata;

    dta_slot_ram #(.AW(AW), .DW(DW)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    logic                  self_act;
    logic [7:0]            self_dep;
    logic [31:0]           self_ret;
    logic [CLOCK_BITS-1:0] self_clk;
    logic                  o_act;
    logic [CLOCK_BITS-1:0] o_clk;
    logic [31:0]           ret_inc;
    logic [AW-1:0]         slot_a;

    // own slot word: straight from the memory while modifying, held copy after
    assign {self_act, self_dep, self_ret, self_clk} = (r_state == ST_MOD) ? rdata : r_self;
    assign o_act   = rdata[DW-1];
    assign o_clk   = rdata[CLOCK_BITS-1:0];
    assign ret_inc = (self_ret == dta_pkg::COUNT_MAX) ? self_ret : self_ret + 32'd1;
    assign slot_a  = AW'(r_item.slot);

    assign in_ch.ready  = (r_state == ST_IDLE) && !r_ovalid;
    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = r_out;

    // read address: the item's slot, else the scan pointer
    always_comb begin
        raddr = (r_state == ST_SCAN) ? r_idx[AW-1:0] : slot_a;
    end

    // write-back of the modified word
    always_comb begin
        we    = 1'b0;
        waddr = slot_a;
        wdata = r_self;
        if (r_state == ST_READ && r_item.op == dta_pkg::OP_ALLOC) begin
            we    = (r_used < CW'(SLOTS));
            waddr = r_used[AW-1:0];
            wdata = {1'b1, {(DW-1){1'b0}}};
        end else if (r_state == ST_MOD && r_reg && r_enable) begin
            case (r_item.op)
                dta_pkg::OP_ACQUIRED: begin
                    if (self_dep != dta_pkg::DEPTH_MAX) begin
                        we    = 1'b1;
                        wdata = {self_act, self_dep + 8'd1, self_ret,
                                 (self_dep == 8'd0 && self_clk != CLOCK_MAX)
                                 ? self_clk + 1'b1 : self_clk};
                    end
                end
                dta_pkg::OP_RELEASED: begin
                    if (self_dep != 8'd0) begin
                        we    = 1'b1;
                        wdata = {self_act, self_dep - 8'd1, self_ret, self_clk};
                    end
                end
                dta_pkg::OP_PARK: begin
                    we    = 1'b1;
                    wdata = {1'b0, self_dep, self_ret, self_clk};
                end
                dta_pkg::OP_RESUME: begin
                    we    = 1'b1;
                    wdata = {1'b1, self_dep, self_ret,
                             (r_item.with_advance && self_clk != CLOCK_MAX)
                             ? self_clk + 1'b1 : self_clk};
                end
                default: we = 1'b0;
            endcase
        end else if (r_state == ST_DONE) begin
            we = 1'b1;
            if (!r_lose || (r_cap != 32'd0 && ret_inc >= r_cap)) begin
                wdata = {self_act, self_dep, 32'd0, self_clk};
            end else begin
                wdata = {self_act, self_dep, ret_inc, self_clk};
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_cap    <= dta_pkg::RETRY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dta_pkg::CFG_ENABLE:    r_enable <= i_cfg_data[0];
                dta_pkg::CFG_RETRY_CAP: r_cap    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_used   <= '0;
            r_relax  <= '0;
            r_ovalid <= 1'b0;
            r_scan_v <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_ch.valid && in_ch.ready) begin
                        r_item  <= in_ch.data;
                        r_out   <= '0;
                        r_reg   <= (32'(in_ch.data.slot) < 32'(r_used))
                                   && (32'(in_ch.data.slot) < 32'(SLOTS));
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    if (r_item.op == dta_pkg::OP_ALLOC) begin
                        if (r_used < CW'(SLOTS)) begin
                            r_out.new_slot <= 6'(r_used);
                            r_used         <= r_used + 1'b1;
                        end else begin
                            r_out.table_full <= 1'b1;
                        end
                    end
                    r_state <= ST_MOD;
                end
                ST_MOD: begin
                    r_self <= rdata;
                    if (r_item.op == dta_pkg::OP_PARK && r_reg) begin
                        r_out.was_active <= rdata[DW-1];
                    end
                    if (r_item.op == dta_pkg::OP_REQUEST) begin
                        r_out.grant <= 1'b1;
                    end
                    if (r_item.op == dta_pkg::OP_REQUEST && r_enable && r_reg) begin
                        r_idx    <= '0;
                        r_scan_v <= 1'b0;
                        r_lose   <= 1'b0;
                        r_state  <= (rdata[39+CLOCK_BITS:32+CLOCK_BITS] != 8'd0)
                                    ? ST_DONE : ST_SCAN;
                    end else begin
                        r_state <= ST_OUT;
                    end
                end
                ST_SCAN: begin
                    // compare the word read last cycle, advance the pointer
                    r_scan_v <= (r_idx < r_used);
                    r_scan_a <= r_idx[AW-1:0];
                    if (r_scan_v && o_act && r_scan_a != slot_a &&
                        (o_clk < self_clk || (o_clk == self_clk && r_scan_a < slot_a))) begin
                        r_lose <= 1'b1;
                    end
                    if (r_idx < r_used) begin
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (r_lose) begin
                        if (r_cap != 32'd0 && ret_inc >= r_cap) begin
                            r_out.relaxed <= 1'b1;
                            if (r_relax != dta_pkg::COUNT_MAX) begin
                                r_relax <= r_relax + 32'd1;
                            end
                        end else begin
                            r_out.grant <= 1'b0;
                        end
                    end
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    r_out.relax_total <= r_relax;
                    r_ovalid          <= 1'b1;
                    r_state           <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hdl/dta_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
// Port-level checks on the arbiter
module dta_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       grant,
    input wire logic       relaxed,
    input wire logic       table_full,
    input wire logic [5:0] new_slot
);
    `CHK_CLK(a_relax_grant, i_clk, i_rst_n, out_valid && relaxed |-> grant, "relaxed without grant")
    `CHK_CLK(a_full_slot, i_clk, i_rst_n, out_valid && table_full |-> new_slot == 6'd0, "full with slot")
    `CHK_CLK(a_no_in_busy, i_clk, i_rst_n, out_valid && !out_ready |-> !in_ready, "accept while result held")
    `CHK_CLK(a_out_hold, i_clk, i_rst_n, out_valid && !out_ready |=> out_valid, "result dropped")
    `CHK_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !out_valid, "valid after reset")
endmodule

bind deterministic_turn_arbiter_top dta_checker u_dta_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .grant(out_ch.data.grant), .relaxed(out_ch.data.relaxed),
    .table_full(out_ch.data.table_full), .new_slot(out_ch.data.new_slot)
);
`default_nettype wire
